@@ sv/hkrb_pkg.sv @@
// Shared constants, types and state codes for the HID keyboard report builder.
// Depends on nothing; hkrb_store and the top level import it.
`timescale 1ns / 1ps
`default_nettype none

package hkrb_pkg;

    localparam int BOOT_SLOTS   = 6;
    localparam int BITMAP_BYTES = 16;
    localparam logic [7:0] FIRST_KEY = 8'd4;

    localparam int MEM_DEPTH = BOOT_SLOTS + BITMAP_BYTES;
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int MAX_BYTES = (BOOT_SLOTS > BITMAP_BYTES) ? BOOT_SLOTS : BITMAP_BYTES;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);
    localparam int IDX_W     = 5;

    localparam logic REPORT_BOOT = 1'b0;
    localparam logic REPORT_NKRO = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_BM_RD,
        ST_BM_WR,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WAIT
    } t_state;

    typedef struct packed {
        logic              we;
        logic [MEM_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic [MEM_AW-1:0] raddr;
    } t_mem_req;

endpackage

`default_nettype wire

@@ sv/hkrb_if.sv @@
// Valid/ready channel interfaces: key events in, report bytes out, mode writes.
// Standalone; payload widths follow the fixed field widths of the block.
`timescale 1ns / 1ps
`default_nettype none

interface hkrb_event_if;
    logic       valid;
    logic       ready;
    logic       has_modifier;
    logic [2:0] modifier_index;
    logic [7:0] keycode;
    logic       pressed;

    modport source (output valid, has_modifier, modifier_index, keycode, pressed,
                    input ready);
    modport sink   (input valid, has_modifier, modifier_index, keycode, pressed,
                    output ready);
endinterface

interface hkrb_report_if;
    logic       valid;
    logic       ready;
    logic       report_kind;
    logic [4:0] byte_index;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, report_kind, byte_index, byte_value, last_byte,
                    input ready);
    modport sink   (input valid, report_kind, byte_index, byte_value, last_byte,
                    output ready);
endinterface

interface hkrb_cfg_if;
    logic valid;
    logic ready;
    logic nkro_mode;

    modport source (output valid, nkro_mode, input ready);
    modport sink   (input valid, nkro_mode, output ready);
endinterface

`default_nettype wire

@@ sv/hkrb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module hkrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 22,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ sv/hkrb_store.sv @@
// Report store: boot key slots and NKRO bitmap bytes in one RAM, with
// per-entry valid bits so unwritten entries read as zero. Uses hkrb_pkg, hkrb_ram.
`timescale 1ns / 1ps
`default_nettype none

module hkrb_store
    import hkrb_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_mem_req   i_req,
    output logic      [7:0] o_rdata
);

    logic [MEM_DEPTH-1:0] r_vld;
    logic                 r_rd_vld;
    logic [7:0]           ram_q;

    hkrb_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH),
        .AW    (MEM_AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.we),
        .i_waddr (i_req.waddr),
        .i_wdata (i_req.wdata),
        .i_raddr (i_req.raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_vld[i_req.waddr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_req.raddr];
        end
    end

    assign o_rdata = r_rd_vld ? ram_q : 8'h00;

endmodule

`default_nettype wire

@@ sv/hid_keyboard_report_builder.sv @@
// Top level of the HID keyboard report builder: event sequencer and byte streamer.
// Uses hkrb_pkg, the hkrb interfaces and hkrb_store.
//
// Channels: i_event takes one key event per beat (modifier and/or keycode,
// press or release); o_report gives one report byte per beat; i_cfg writes
// the nkro_mode bit and is always ready.
// One event at a time: i_event is ready only while the sequencer is idle.
// Sequence: a bitmap update reads the bitmap byte, then writes it back; a boot
// slot search reads and checks each slot in turn, up to BOOT_SLOTS slots. Each
// report byte then passes a RAM read, a load of the output register and the
// beat, plus any receiver stall. A boot report is 1 + BOOT_SLOTS bytes, an
// NKRO report 1 + BITMAP_BYTES. The single RAM port and the registered read
// set the pace from one accepted event to the next.
// An event with neither modifier nor key produces no beat and frees i_event
// next cycle; a boot search that changes nothing frees it after the last slot.
// When the receiver stalls, the output register holds its byte and the
// sequencer waits. Reset clears the mode, modifiers and all slot/bitmap
// valid bits at once, so both reports read as empty straight after reset.
`timescale 1ns / 1ps
`default_nettype none

module hid_keyboard_report_builder
    import hkrb_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    hkrb_event_if.sink    i_event,
    hkrb_report_if.source o_report,
    hkrb_cfg_if.sink      i_cfg
);

    t_state           r_state, n_state;
    logic             r_nkro;
    logic [7:0]       r_mods, n_mods;
    logic [7:0]       r_key, n_key;
    logic             r_press, n_press;
    logic [4:0]       r_byte, n_byte;
    logic [2:0]       r_bit, n_bit;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_boot_chg, n_boot_chg;
    logic             r_nkro_chg, n_nkro_chg;
    logic             r_kind, n_kind;

    logic             r_out_valid, n_out_valid;
    logic             r_out_kind, n_out_kind;
    logic [IDX_W-1:0] r_out_idx, n_out_idx;
    logic [7:0]       r_out_val, n_out_val;
    logic             r_out_last, n_out_last;

    t_mem_req         mem_req;
    logic [7:0]       rdata;
    logic [7:0]       key_off;
    logic             in_bitmap;
    logic [7:0]       bit_mask;
    logic [MEM_AW-1:0] bm_addr;

    hkrb_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    assign key_off   = i_event.keycode - FIRST_KEY;
    assign in_bitmap = {1'b0, key_off[7:3]} < 6'(BITMAP_BYTES);
    assign bit_mask  = 8'h01 << r_bit;
    assign bm_addr   = MEM_AW'(BOOT_SLOTS) + MEM_AW'(r_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_nkro      <= 1'b0;
            r_mods      <= 8'h00;
            r_boot_chg  <= 1'b0;
            r_nkro_chg  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mods      <= n_mods;
            r_boot_chg  <= n_boot_chg;
            r_nkro_chg  <= n_nkro_chg;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                r_nkro <= i_cfg.nkro_mode;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_press    <= n_press;
        r_byte     <= n_byte;
        r_bit      <= n_bit;
        r_idx      <= n_idx;
        r_kind     <= n_kind;
        r_out_kind <= n_out_kind;
        r_out_idx  <= n_out_idx;
        r_out_val  <= n_out_val;
        r_out_last <= n_out_last;
    end

    always_comb begin
        logic hit;
        logic end_rep;
        logic nd;

        n_state     = r_state;
        n_mods      = r_mods;
        n_key       = r_key;
        n_press     = r_press;
        n_byte      = r_byte;
        n_bit       = r_bit;
        n_idx       = r_idx;
        n_boot_chg  = r_boot_chg;
        n_nkro_chg  = r_nkro_chg;
        n_kind      = r_kind;
        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_idx   = r_out_idx;
        n_out_val   = r_out_val;
        n_out_last  = r_out_last;
        mem_req     = '0;
        hit         = 1'b0;
        end_rep     = 1'b0;
        nd          = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_event.valid) begin
                    n_boot_chg = 1'b0;
                    n_nkro_chg = 1'b0;
                    if (i_event.has_modifier) begin
                        n_mods = i_event.pressed
                               ? (r_mods | (8'h01 << i_event.modifier_index))
                               : (r_mods & ~(8'h01 << i_event.modifier_index));
                        nd         = r_nkro;
                        n_boot_chg = !r_nkro;
                        n_nkro_chg = r_nkro;
                    end
                    n_key   = i_event.keycode;
                    n_press = i_event.pressed;
                    n_byte  = key_off[7:3];
                    n_bit   = key_off[2:0];
                    n_idx   = '0;
                    if (i_event.keycode != 8'h00) begin
                        if (r_nkro && in_bitmap) begin
                            n_state = ST_BM_RD;
                        end else begin
                            n_state = ST_SCAN_RD;
                        end
                    end else if (i_event.has_modifier) begin
                        n_kind  = nd ? REPORT_NKRO : REPORT_BOOT;
                        n_state = ST_OUT_RD;
                    end
                end
            end
            ST_SCAN_RD: begin
                mem_req.raddr = MEM_AW'(r_idx);
                n_state       = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                hit = r_press ? (rdata == 8'h00 || rdata == r_key) : (rdata == r_key);
                if (hit) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = MEM_AW'(r_idx);
                    mem_req.wdata = r_press ? r_key : 8'h00;
                    n_boot_chg    = 1'b1;
                    n_kind        = REPORT_BOOT;
                    n_idx         = '0;
                    n_state       = ST_OUT_RD;
                end else if (r_idx == CNT_W'(BOOT_SLOTS - 1)) begin
                    n_idx = '0;
                    if (r_boot_chg || r_nkro_chg) begin
                        n_kind  = r_boot_chg ? REPORT_BOOT : REPORT_NKRO;
                        n_state = ST_OUT_RD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_idx   = r_idx + CNT_W'(1);
                    n_state = ST_SCAN_RD;
                end
            end
            ST_BM_RD: begin
                mem_req.raddr = bm_addr;
                n_state       = ST_BM_WR;
            end
            ST_BM_WR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = bm_addr;
                mem_req.wdata = r_press ? (rdata | bit_mask) : (rdata & ~bit_mask);
                n_nkro_chg    = 1'b1;
                n_kind        = r_boot_chg ? REPORT_BOOT : REPORT_NKRO;
                n_idx         = '0;
                n_state       = ST_OUT_RD;
            end
            ST_OUT_RD: begin
                if (r_kind == REPORT_NKRO) begin
                    mem_req.raddr = MEM_AW'(BOOT_SLOTS) + MEM_AW'(r_idx) - MEM_AW'(1);
                end else begin
                    mem_req.raddr = MEM_AW'(r_idx) - MEM_AW'(1);
                end
                n_state = ST_OUT_LD;
            end
            ST_OUT_LD: begin
                n_out_valid = 1'b1;
                n_out_kind  = r_kind;
                n_out_idx   = IDX_W'(r_idx);
                n_out_val   = (r_idx == '0) ? r_mods : rdata;
                if (r_kind == REPORT_NKRO) begin
                    n_out_last = (r_idx == CNT_W'(BITMAP_BYTES));
                end else begin
                    n_out_last = (r_idx == CNT_W'(BOOT_SLOTS)) && !r_nkro_chg;
                end
                n_state = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
                if (o_report.ready) begin
                    n_out_valid = 1'b0;
                    end_rep = (r_kind == REPORT_NKRO) ? (r_idx == CNT_W'(BITMAP_BYTES))
                                                      : (r_idx == CNT_W'(BOOT_SLOTS));
                    if (end_rep) begin
                        n_idx = '0;
                        if (r_kind == REPORT_BOOT && r_nkro_chg) begin
                            n_kind  = REPORT_NKRO;
                            n_state = ST_OUT_RD;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_idx   = r_idx + CNT_W'(1);
                        n_state = ST_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign i_event.ready        = (r_state == ST_IDLE);
    assign i_cfg.ready          = 1'b1;
    assign o_report.valid       = r_out_valid;
    assign o_report.report_kind = r_out_kind;
    assign o_report.byte_index  = r_out_idx;
    assign o_report.byte_value  = r_out_val;
    assign o_report.last_byte   = r_out_last;

endmodule

`default_nettype wire
